// ===== rtl/tti_pkg.sv =====
// Shared types, character codes and helper functions of the text to integer parser.
// No dependencies; every other file of the block imports this package.
package tti_pkg;

  // Default limit of the consumed character count
  localparam int unsigned MAX_CHARS_DEF = 1023;

  // Field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned BaseW  = 6;
  localparam int unsigned ValueW = 64;
  localparam int unsigned OffW   = 10;
  localparam int unsigned DigitW = 7;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 80;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_NUMBER_BASE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIGNED_MODE = 1'd1;

  // Character codes
  localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CharW-1:0] CHAR_LC_Z  = 8'h7a;
  localparam logic [CharW-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CharW-1:0] CHAR_UC_Z  = 8'h5a;
  localparam logic [CharW-1:0] CHAR_LC_X  = 8'h78;
  localparam logic [CharW-1:0] CHAR_UC_X  = 8'h58;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CharW-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CharW-1:0] CHAR_CR    = 8'h0d;

  // Radix values
  localparam logic [BaseW-1:0] BASE_AUTO = 6'd0;
  localparam logic [BaseW-1:0] BASE_OCT  = 6'd8;
  localparam logic [BaseW-1:0] BASE_DEC  = 6'd10;
  localparam logic [BaseW-1:0] BASE_HEX  = 6'd16;

  // Marks a character that is no digit in any radix
  localparam logic [DigitW-1:0] DIGIT_NONE = 7'd64;

  // Parse phases, one-hot
  typedef enum logic [5:0] {
    PH_SIGN   = 6'b000001,
    PH_PLUS   = 6'b000010,
    PH_PREFIX = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } tti_phase_e;

  // One accepted input transaction
  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } tti_item_t;

  // One result
  typedef struct packed {
    logic [ValueW-1:0] parsed_value;
    logic [OffW-1:0]   end_offset;
    logic              offset_saturated;
  } tti_result_t;

  // Space and the control codes tab through carriage return
  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
  endfunction

  // Digit value of an alphanumeric character, DIGIT_NONE otherwise
  function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] diff;
    diff = '0;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      diff = c - CHAR_ZERO;
    end else if (c inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
      diff = c - CHAR_LC_A + 8'd10;
    end else if (c inside {[CHAR_UC_A:CHAR_UC_Z]}) begin
      diff = c - CHAR_UC_A + 8'd10;
    end else begin
      diff = {1'b0, DIGIT_NONE};
    end
    return diff[DigitW-1:0];
  endfunction

endpackage

// ===== rtl/tti_in_stage.sv =====
// Input register of the parser: holds one character transaction for the step logic.
// Depends on tti_pkg.
module tti_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  tti_pkg::tti_item_t       in_item_i,
  output logic                     item_valid_o,
  output tti_pkg::tti_item_t       item_o,
  input  logic                     item_take_i
);
  import tti_pkg::*;

  logic      valid_q, valid_d;
  tti_item_t item_q;

  // Accept when empty or when the held item moves on in this cycle
  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/tti_core.sv =====
// Parse state and per-character step logic of the parser, plus the configuration registers.
// Depends on tti_pkg.
module tti_core #(
  parameter int unsigned MaxChars = tti_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tti_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tti_pkg::BaseW-1:0]     cfg_data_i,
  input  logic                          item_valid_i,
  input  tti_pkg::tti_item_t            item_i,
  output logic                          item_take_o,
  input  logic                          out_busy_i,
  output logic                          res_valid_o,
  output tti_pkg::tti_result_t          res_o
);
  import tti_pkg::*;

  localparam int unsigned PosW = $clog2(MaxChars + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxChars);

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            clamped;
  } tti_pos_t;

  // Count one consumed character, clamping at the limit
  function automatic tti_pos_t advance(input tti_pos_t p);
    tti_pos_t r;
    r = p;
    if (p.pos < PosMax) begin
      r.pos = p.pos + 1'b1;
    end else begin
      r.clamped = 1'b1;
    end
    return r;
  endfunction

  // Configuration registers
  logic [BaseW-1:0] number_base_q;
  logic             signed_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_AUTO;
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUMBER_BASE: number_base_q <= cfg_data_i;
        CFG_SIGNED_MODE: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Parse state
  tti_phase_e        phase_q, phase_d;
  logic [BaseW-1:0]  base_q, base_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              minus_q, minus_d;
  tti_pos_t          pos_q, pos_d;

  // A final character needs a free result register
  assign item_take_o = item_valid_i && (!item_i.last_char || !out_busy_i);

  // Step logic for one character
  always_comb begin
    logic [CharW-1:0]  c;
    logic [DigitW-1:0] d;
    logic              fin;
    tti_phase_e        ph;
    logic [BaseW-1:0]  base;
    logic [ValueW-1:0] acc;
    logic              minus;
    tti_pos_t          pos;
    c     = item_i.char_code;
    d     = digit_of(c);
    fin   = 1'b0;
    ph    = phase_q;
    base  = base_q;
    acc   = acc_q;
    minus = minus_q;
    pos   = pos_q;

    // Leading blanks, then one sign in signed mode
    if (ph == PH_SIGN) begin
      if (is_blank(c)) begin
        pos = advance(pos);
        fin = 1'b1;
      end else begin
        ph = PH_PLUS;
        if (signed_mode_q && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
          if (c == CHAR_MINUS) begin
            minus = 1'b1;
          end
          pos = advance(pos);
          fin = 1'b1;
        end
      end
    end
    // Blanks again, then an optional plus
    if (!fin && ph == PH_PLUS) begin
      if (is_blank(c)) begin
        pos = advance(pos);
        fin = 1'b1;
      end else begin
        ph = PH_PREFIX;
        if (c == CHAR_PLUS) begin
          pos = advance(pos);
          fin = 1'b1;
        end
      end
    end
    // Decide the radix; a leading zero is held for a possible 0x
    if (!fin && ph == PH_PREFIX) begin
      if ((number_base_q == BASE_AUTO || number_base_q == BASE_HEX) && c == CHAR_ZERO) begin
        base = (number_base_q == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        ph   = PH_ZERO;
        fin  = 1'b1;
      end else begin
        base = (number_base_q == BASE_AUTO) ? BASE_DEC : number_base_q;
        ph   = PH_DIGITS;
      end
    end
    // After the held zero: take x as hex prefix, else count the zero as a digit
    if (!fin && ph == PH_ZERO) begin
      if (c == CHAR_LC_X || c == CHAR_UC_X) begin
        base = BASE_HEX;
        pos  = advance(advance(pos));
        ph   = PH_DIGITS;
        fin  = 1'b1;
      end else begin
        acc = '0;
        pos = advance(pos);
        ph  = PH_DIGITS;
      end
    end
    // Accumulate digits below the radix, stop at anything else
    if (!fin && ph == PH_DIGITS) begin
      if (d < {1'b0, base}) begin
        acc = acc * {{(ValueW-BaseW){1'b0}}, base} + {{(ValueW-DigitW){1'b0}}, d};
        pos = advance(pos);
      end else begin
        ph = PH_DONE;
      end
    end
    // String ends on the held zero: it is a digit
    if (item_i.last_char && ph == PH_ZERO) begin
      acc = '0;
      pos = advance(pos);
    end

    phase_d = ph;
    base_d  = base;
    acc_d   = acc;
    minus_d = minus;
    pos_d   = pos;
  end

  // Build the result from the stepped state
  always_comb begin
    logic [OffW+PosW-1:0] pos_ext;
    pos_ext                = {{OffW{1'b0}}, pos_d.pos};
    res_valid_o            = item_take_o && item_i.last_char;
    res_o.parsed_value     = (signed_mode_q && minus_d) ? (ValueW'(0) - acc_d) : acc_d;
    res_o.end_offset       = pos_ext[OffW-1:0];
    res_o.offset_saturated = pos_d.clamped;
  end

  // Advance on each taken character, clear after a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIGN;
      base_q  <= '0;
      acc_q   <= '0;
      minus_q <= 1'b0;
      pos_q   <= '0;
    end else if (item_take_o) begin
      if (item_i.last_char) begin
        phase_q <= PH_SIGN;
        base_q  <= '0;
        acc_q   <= '0;
        minus_q <= 1'b0;
        pos_q   <= '0;
      end else begin
        phase_q <= phase_d;
        base_q  <= base_d;
        acc_q   <= acc_d;
        minus_q <= minus_d;
        pos_q   <= pos_d;
      end
    end
  end

endmodule

// ===== rtl/tti_out_stage.sv =====
// Result register of the parser: holds one result transaction until the receiver takes it.
// Depends on tti_pkg.
module tti_out_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  input  tti_pkg::tti_result_t              res_i,
  output logic                              out_busy_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tti_pkg::OutDataW-1:0]      out_data_o
);
  import tti_pkg::*;

  logic        valid_q, valid_d;
  tti_result_t res_q;

  // Occupied and not drained in this cycle
  assign out_busy_o = valid_q && !out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  // Pack value, offset and saturation flag from the lowest bit up
  assign out_valid_o = valid_q;
  assign out_data_o  = {{(OutDataW-ValueW-OffW-1){1'b0}},
                        res_q.offset_saturated, res_q.end_offset, res_q.parsed_value};

endmodule

// ===== rtl/text_to_integer_parser.sv =====
// Text to integer parser, top level: stream in characters, stream out one value per string.
// Depends on tti_pkg, tti_in_stage, tti_core and tti_out_stage.
//
// Usage:
//   The slave stream carries one character per transaction in s_axis_tdata; s_axis_tlast
//   marks the final character of a string. Each string yields one transaction on the
//   master stream: the parsed 64-bit value, the consumed character count and a flag
//   that the count clamped at MaxChars.
//   The configuration port writes the radix (index 0) and signed mode (index 1) on any
//   clock with cfg_we_i high; write it only while no string is in flight.
// Flow:
//   One character per cycle while no final character waits for the result register.
//   A final character passes from the input register through the step logic into the
//   result register, which drives the master side. Each character is stepped through
//   one 64x6 multiply-add between the input and result registers.
// Reset:
//   Clears the parse state, both stages and the configuration (radix 0, unsigned).
// Stall:
//   A waiting result holds in the result register; ordinary characters still flow in.
//   A final character waits in the input register until the result register frees up,
//   and the slave side then backs up by one transaction.
module text_to_integer_parser #(
  parameter int unsigned MaxChars = tti_pkg::MAX_CHARS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tti_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tti_pkg::BaseW-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] char_code
  input  logic [tti_pkg::InDataW-1:0]       s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] parsed_value, [73:64] end_offset, [74] offset_saturated, [79:75] zero
  output logic [tti_pkg::OutDataW-1:0]      m_axis_tdata
);
  import tti_pkg::*;

  tti_item_t   in_item;
  tti_item_t   item;
  logic        item_valid;
  logic        item_take;
  logic        out_busy;
  logic        res_valid;
  tti_result_t res;

  assign in_item.char_code = s_axis_tdata[CharW-1:0];
  assign in_item.last_char = s_axis_tlast;

  tti_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  tti_core #(
    .MaxChars (MaxChars)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_busy_i   (out_busy),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  tti_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_busy_o  (out_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/tti_checker.sv =====
// Port-level checks of the text to integer parser, bound to the top level.
// Depends on tti_pkg and text_to_integer_parser.
module tti_checker #(
  parameter int unsigned MaxChars = tti_pkg::MAX_CHARS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tlast,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tti_pkg::OutDataW-1:0] m_axis_tdata
);
  import tti_pkg::*;

  localparam logic [OffW-1:0] OffMax = OffW'(MaxChars);
  localparam logic            SmallLimit = (MaxChars < 1024);

  logic              s_acc;
  logic [ValueW-1:0] value;
  logic [OffW-1:0]   offset;
  logic              sat;

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign value  = m_axis_tdata[ValueW-1:0];
  assign offset = m_axis_tdata[ValueW+OffW-1:ValueW];
  assign sat    = m_axis_tdata[ValueW+OffW];

  // Stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A final character brings a result to the master side when the receiver is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after final character");

  // A clamped count sits at the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sat |-> offset == OffMax)
    else $error("saturated offset not at limit");

  // Nothing consumed means a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && SmallLimit && offset == '0 |-> value == '0)
    else $error("nonzero value with nothing consumed");

endmodule

bind text_to_integer_parser tti_checker #(
  .MaxChars (MaxChars)
) u_tti_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
